FILE: sv/itrd_pkg.sv
// Shared types, constants and helpers for the integer to radix digits block.
// Used by every module of the block but itrd_ram; depends on nothing else.
`default_nettype none

package itrd_pkg;

   localparam int VALUE_BITS     = 32;
   localparam int MAX_RADIX      = 16;
   localparam int CHAR_BITS      = 8;
   localparam int REM_W          = $clog2(MAX_RADIX);
   localparam int DIVISOR_W      = $clog2(MAX_RADIX) + 1;
   localparam int BITS_PER_CYCLE = 4;
   localparam int DIV_CYCLES     = VALUE_BITS / BITS_PER_CYCLE;
   localparam int DIV_CNT_W      = $clog2(DIV_CYCLES);
   localparam int DIGIT_DEPTH    = VALUE_BITS;
   localparam int DIGIT_IDX_W    = $clog2(DIGIT_DEPTH);
   localparam int DIGIT_TOTAL_W  = $clog2(DIGIT_DEPTH) + 1;
   localparam int ALPHA_BITS     = MAX_RADIX * CHAR_BITS;
   localparam int CSR_IDX_W      = 2;
   localparam int CSR_DATA_W     = 64;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_SIZE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIGITS_LOW  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DIGITS_HIGH = 2'd2;

   localparam logic [CHAR_BITS-1:0] CHAR_NUL   = 8'h00;
   localparam logic [CHAR_BITS-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'h2D;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_SIGN,
      ST_READ,
      ST_EMIT,
      ST_ERROR
   } state_type;

   typedef struct packed {
      logic             done;
      logic [REM_W-1:0] remainder;
   } div_status_type;

   // Picks character k of the packed alphabet; character 0 sits in the low byte.
   function automatic logic [CHAR_BITS-1:0] alpha_char(
      input logic [ALPHA_BITS-1:0] digits,
      input logic [REM_W-1:0]      k
   );
      return digits[k*CHAR_BITS +: CHAR_BITS];
   endfunction

endpackage : itrd_pkg

`default_nettype wire

FILE: sv/itrd_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; holds the digit indices of the block.
`default_nettype none

module itrd_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule : itrd_ram

`default_nettype wire

FILE: sv/itrd_divider.sv
// Iterative restoring divider: divides the magnitude by the radix, a few
// quotient bits per cycle. Depends on itrd_pkg.
`default_nettype none

module itrd_divider (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   start,
   input  wire logic [itrd_pkg::VALUE_BITS-1:0]        dividend,
   input  wire logic [itrd_pkg::DIVISOR_W-1:0]         divisor,
   output itrd_pkg::div_status_type                    status,
   output logic      [itrd_pkg::VALUE_BITS-1:0]        quotient
);

   import itrd_pkg::*;

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [DIV_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [VALUE_BITS-1:0]   quo_ff, quo_in;
   logic [REM_W-1:0]        rem_ff, rem_in;
   logic [DIVISOR_W-1:0]    divisor_ff, divisor_in;
   logic [VALUE_BITS-1:0]   quo_step;
   logic [REM_W-1:0]        rem_step;
   logic [REM_W:0]          trial;

   // Several restoring steps per cycle; the partial remainder stays below the
   // divisor, so it never needs more than REM_W bits.
   always_comb begin
      rem_step = rem_ff;
      quo_step = quo_ff;
      trial    = '0;
      for (int s = 0; s < BITS_PER_CYCLE; s++) begin
         trial    = {rem_step, quo_step[VALUE_BITS-1]};
         quo_step = {quo_step[VALUE_BITS-2:0], 1'b0};
         if (trial >= divisor_ff) begin
            rem_step    = REM_W'(trial - divisor_ff);
            quo_step[0] = 1'b1;
         end else begin
            rem_step = trial[REM_W-1:0];
         end
      end
   end

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         cnt_in     = '0;
         quo_in     = dividend;
         rem_in     = '0;
         divisor_in = divisor;
      end else if (busy_ff) begin
         quo_in = quo_step;
         rem_in = rem_step;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_CYCLES - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign status.done      = done_ff;
   assign status.remainder = rem_ff;
   assign quotient         = quo_ff;

endmodule : itrd_divider

`default_nettype wire

FILE: sv/itrd_alpha_check.sv
// Alphabet validation: radix range, forbidden characters and repeats.
// Depends on itrd_pkg.
`default_nettype none

module itrd_alpha_check (
   input  wire logic [itrd_pkg::DIVISOR_W-1:0]  base_size,
   input  wire logic [itrd_pkg::ALPHA_BITS-1:0] digits,
   output logic                                 alpha_ok
);

   import itrd_pkg::*;

   logic [MAX_RADIX-1:0] in_use;
   logic [MAX_RADIX-1:0] bad_char;
   logic [MAX_RADIX-1:0] repeated;
   logic                 range_ok;
   logic [CHAR_BITS-1:0] ci;

   assign range_ok = (base_size >= DIVISOR_W'(2)) && (base_size <= DIVISOR_W'(MAX_RADIX));

   always_comb begin
      ci       = '0;
      in_use   = '0;
      bad_char = '0;
      repeated = '0;
      for (int i = 0; i < MAX_RADIX; i++) begin
         ci        = alpha_char(digits, REM_W'(i));
         in_use[i] = DIVISOR_W'(i) < base_size;
         bad_char[i] = in_use[i] &&
                       (ci == CHAR_NUL || ci == CHAR_PLUS || ci == CHAR_MINUS);
         for (int j = i + 1; j < MAX_RADIX; j++) begin
            if (DIVISOR_W'(j) < base_size && alpha_char(digits, REM_W'(j)) == ci) begin
               repeated[i] = 1'b1;
            end
         end
      end
   end

   assign alpha_ok = range_ok && (bad_char == '0) && (repeated == '0);

endmodule : itrd_alpha_check

`default_nettype wire

FILE: sv/integer_to_radix_digits_top.sv
// Converts a signed 32-bit integer into its text in a configured radix, one
// character per response, most significant digit first, with a leading '-'
// for negative values. The radix is the size of a configured alphabet of 2 to
// 16 distinct characters; an invalid alphabet gives a single error response.
// One request is handled at a time. Each digit takes one pass of the shared
// divider, at 4 quotient bits per cycle, through ST_DIV_START and ST_DIV_WAIT;
// each digit character is then fetched from the digit RAM in ST_READ and sent
// in ST_EMIT, after a leading '-' sent in ST_SIGN for a negative value. A new
// request is taken in the cycle after the last character has been placed in
// the output register.
// Depends on itrd_pkg, itrd_divider, itrd_alpha_check and itrd_ram.
`default_nettype none

module integer_to_radix_digits_top (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic signed [itrd_pkg::VALUE_BITS-1:0] req_value,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic      [itrd_pkg::CHAR_BITS-1:0]        rsp_character,
   output logic                                       rsp_last,
   output logic                                       rsp_base_error,
   input  wire logic                                  csr_write,
   input  wire logic [itrd_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [itrd_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   import itrd_pkg::*;

   state_type                state_ff, state_in;

   logic [DIVISOR_W-1:0]     base_size_ff;
   logic [CSR_DATA_W-1:0]    digits_low_ff;
   logic [CSR_DATA_W-1:0]    digits_high_ff;
   logic [ALPHA_BITS-1:0]    digits;

   logic                     neg_ff;
   logic [VALUE_BITS-1:0]    mag_ff, mag_in;
   logic [DIGIT_TOTAL_W-1:0] total_ff, total_in;

   logic                     rsp_valid_ff;
   logic [CHAR_BITS-1:0]     rsp_char_ff;
   logic                     rsp_last_ff;
   logic                     rsp_err_ff;

   logic                     slot_free;
   logic                     out_load;
   logic [CHAR_BITS-1:0]     out_char;
   logic                     out_last;
   logic                     out_err;
   logic                     accept;
   logic                     div_start;
   logic                     ram_we;
   logic                     alpha_ok;
   logic                     more_digits;

   div_status_type           div_status;
   logic [VALUE_BITS-1:0]    div_quotient;
   logic [DIGIT_IDX_W-1:0]   ram_raddr;
   logic [REM_W-1:0]         ram_rdata;
   logic [DIGIT_TOTAL_W-1:0] total_next;

   assign digits = {digits_high_ff, digits_low_ff};

   itrd_alpha_check u_check (
      .base_size (base_size_ff),
      .digits    (digits),
      .alpha_ok  (alpha_ok)
   );

   itrd_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mag_ff),
      .divisor  (base_size_ff),
      .status   (div_status),
      .quotient (div_quotient)
   );

   itrd_ram #(
      .WIDTH (REM_W),
      .DEPTH (DIGIT_DEPTH)
   ) u_digit_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (total_ff[DIGIT_IDX_W-1:0]),
      .wr_data (div_status.remainder),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Digits are read back from the most significant end; total_ff counts down.
   assign ram_raddr   = DIGIT_IDX_W'(total_ff - 1'b1);
   assign total_next  = total_ff + 1'b1;
   assign more_digits = (div_quotient != '0) &&
                        (total_next < DIGIT_TOTAL_W'(DIGIT_DEPTH));
   assign slot_free   = !rsp_valid_ff || !rsp_stall;
   assign accept      = req_valid && !req_stall;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         base_size_ff   <= '0;
         digits_low_ff  <= '0;
         digits_high_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_BASE_SIZE:   base_size_ff   <= csr_wdata[DIVISOR_W-1:0];
            CSR_DIGITS_LOW:  digits_low_ff  <= csr_wdata;
            CSR_DIGITS_HIGH: digits_high_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (req_valid) state_in = ST_CHECK;
         ST_CHECK:     state_in = alpha_ok ? ST_DIV_START : ST_ERROR;
         ST_DIV_START: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (div_status.done) begin
               if (more_digits) begin
                  state_in = ST_DIV_START;
               end else begin
                  state_in = neg_ff ? ST_SIGN : ST_READ;
               end
            end
         end
         ST_SIGN:      if (slot_free) state_in = ST_READ;
         ST_READ:      state_in = ST_EMIT;
         ST_EMIT: begin
            if (slot_free) begin
               state_in = (total_ff == DIGIT_TOTAL_W'(1)) ? ST_IDLE : ST_READ;
            end
         end
         ST_ERROR:     if (slot_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      req_stall = 1'b1;
      div_start = 1'b0;
      ram_we    = 1'b0;
      out_load  = 1'b0;
      out_char  = CHAR_NUL;
      out_last  = 1'b0;
      out_err   = 1'b0;
      unique case (state_ff)
         ST_IDLE:      req_stall = 1'b0;
         ST_CHECK:     ;
         ST_DIV_START: div_start = 1'b1;
         ST_DIV_WAIT:  ram_we = div_status.done;
         ST_SIGN: begin
            out_load = slot_free;
            out_char = CHAR_MINUS;
         end
         ST_READ:      ;
         ST_EMIT: begin
            out_load = slot_free;
            out_char = alpha_char(digits, ram_rdata);
            out_last = (total_ff == DIGIT_TOTAL_W'(1));
         end
         ST_ERROR: begin
            out_load = slot_free;
            out_last = 1'b1;
            out_err  = 1'b1;
         end
         default:      ;
      endcase
   end

   // Working magnitude and digit count.
   always_comb begin
      mag_in   = mag_ff;
      total_in = total_ff;
      if (accept) begin
         mag_in = req_value[VALUE_BITS-1] ? (~req_value + 1'b1) : req_value;
      end
      if (state_ff == ST_CHECK) begin
         total_in = '0;
      end
      if (ram_we) begin
         mag_in   = div_quotient;
         total_in = total_next;
      end
      if (state_ff == ST_EMIT && slot_free) begin
         total_in = total_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         total_ff     <= '0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      mag_ff <= mag_in;
      if (accept) begin
         neg_ff <= req_value[VALUE_BITS-1];
      end
      if (out_load) begin
         rsp_char_ff <= out_char;
         rsp_last_ff <= out_last;
         rsp_err_ff  <= out_err;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_character  = rsp_char_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_base_error = rsp_err_ff;

endmodule : integer_to_radix_digits_top

`default_nettype wire

FILE: sim/tb_top.sv
// Self-checking testbench for integer_to_radix_digits_top: directed table then random requests,
// every response compared with an in-bench prediction of the digit text.
// Depends on itrd_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_top;
   import itrd_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int RANDOM_REQUESTS = 256;
   localparam int IDLE_PERCENT    = 23;
   localparam int DRAIN_CYCLES    = 400;
   // The limit allows for about 280 requests, each of up to 33 responses, with
   // random stalls.
   localparam int LIMIT_CYCLES    = 1_000_000;

   localparam logic [63:0] DEC_LO  = 64'h3736_3534_3332_3130;
   localparam logic [63:0] DEC_HI  = 64'h0000_0000_0000_3938;
   localparam logic [63:0] HEX_HI  = 64'h4645_4443_4241_3938;
   localparam logic [63:0] BIN_LO  = 64'h0000_0000_0000_3130;
   localparam logic [63:0] ODD_LO  = 64'hFF80_7F01_AA55_C33C;
   localparam logic [63:0] ODD_HI  = 64'hFEE1_1E02_4020_1008;

   typedef struct packed {
      logic [CHAR_BITS-1:0] character;
      logic                 last;
      logic                 base_error;
   } char_result_type;

   typedef struct {
      bit                    reconfigure;
      logic [63:0]           base_w;
      logic [63:0]           lo;
      logic [63:0]           hi;
      logic [VALUE_BITS-1:0] value;
      bit                    typed;
      string                 text;
      bit                    err;
   } directed_row_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic signed [VALUE_BITS-1:0]  req_value = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [CHAR_BITS-1:0]          rsp_character;
   logic                          rsp_last;
   logic                          rsp_base_error;
   logic                          csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]          csr_index = '0;
   logic [CSR_DATA_W-1:0]         csr_wdata = '0;

   // Shadow copy of the block's configuration.
   logic [4:0]          radix_cfg = '0;
   logic [63:0]         alpha_lo  = '0;
   logic [63:0]         alpha_hi  = '0;

   char_result_type     expected_chars[$];
   directed_row_type    directed[$];
   int                  mismatches = 0;
   int                  cycles = 0;
   bit                  no_idle = 1'b0;

   integer_to_radix_digits_top i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_character  (rsp_character),
      .rsp_last       (rsp_last),
      .rsp_base_error (rsp_base_error),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Works out the characters that one request produces under the current alphabet.
   function automatic void predict_text(input logic [VALUE_BITS-1:0] v);
      logic [127:0]          pool;
      logic [7:0]            c;
      logic [VALUE_BITS-1:0] mag;
      logic [VALUE_BITS-1:0] divisor;
      logic [3:0]            digs[VALUE_BITS];
      bit                    ok;
      int                    n;
      pool = {alpha_hi, alpha_lo};
      ok = (radix_cfg >= 2) && (radix_cfg <= MAX_RADIX);
      for (int i = 0; i < MAX_RADIX && i < radix_cfg; i++) begin
         c = pool[i*8 +: 8];
         if (c == CHAR_NUL || c == CHAR_PLUS || c == CHAR_MINUS)
            ok = 1'b0;
         for (int j = i + 1; j < MAX_RADIX && j < radix_cfg; j++)
            if (pool[j*8 +: 8] == c)
               ok = 1'b0;
      end
      if (!ok) begin
         expected_chars.push_back('{character: CHAR_NUL, last: 1'b1, base_error: 1'b1});
         return;
      end
      mag = v[VALUE_BITS-1] ? (~v + 1'b1) : v;
      divisor = {27'd0, radix_cfg};
      n = 0;
      do begin
         digs[n] = 4'(mag % divisor);
         mag = mag / divisor;
         n++;
      end while (mag != 0 && n < VALUE_BITS);
      if (v[VALUE_BITS-1])
         expected_chars.push_back('{character: CHAR_MINUS, last: 1'b0, base_error: 1'b0});
      for (int k = n - 1; k >= 0; k--)
         expected_chars.push_back('{character: pool[digs[k]*8 +: 8], last: (k == 0),
                                    base_error: 1'b0});
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Stops sending and waits until every expected character has arrived.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_chars.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // Registers are only written once the block has gone idle.
   task automatic apply_config(input logic [63:0] base_w, input logic [127:0] alpha);
      wait_drained();
      write_reg(CSR_BASE_SIZE, base_w);
      radix_cfg = base_w[4:0];
      write_reg(CSR_DIGITS_LOW, alpha[63:0]);
      alpha_lo = alpha[63:0];
      write_reg(CSR_DIGITS_HIGH, alpha[127:64]);
      alpha_hi = alpha[127:64];
      // A write beyond the last register must leave the configuration alone.
      write_reg(CSR_UNUSED, {$urandom, $urandom});
      csr_write <= 1'b0;
   endtask

   task automatic send_request(input logic [VALUE_BITS-1:0] v);
      if (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < IDLE_PERCENT) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   initial begin
      logic [127:0]          alpha;
      logic [63:0]           base_w;
      logic [VALUE_BITS-1:0] v;
      logic [7:0]            c;
      bit                    used[256];
      int                    base;
      int                    burst;
      int                    random_items;
      int                    i;
      int                    j;

      // reconfigure, base write, low chars, high chars, value, typed, text, error
      directed.push_back('{0, 64'd0, 64'd0, 64'd0, 32'd5, 1, "", 1});
      directed.push_back('{1, 64'd10, DEC_LO, DEC_HI, 32'd0, 1, "0", 0});
      directed.push_back('{0, 64'd0, 64'd0, 64'd0, 32'd9, 1, "9", 0});
      directed.push_back('{0, 64'd0, 64'd0, 64'd0, 32'd10, 1, "10", 0});
      directed.push_back('{0, 64'd0, 64'd0, 64'd0, 32'h7FFF_FFFF, 1, "2147483647", 0});
      directed.push_back('{0, 64'd0, 64'd0, 64'd0, 32'h8000_0000, 1, "-2147483648", 0});
      directed.push_back('{0, 64'd0, 64'd0, 64'd0, 32'hFFFF_FFFF, 1, "-1", 0});
      directed.push_back('{1, 64'd16, DEC_LO, HEX_HI, 32'h8000_0000, 1, "-80000000", 0});
      directed.push_back('{0, 64'd0, 64'd0, 64'd0, 32'h7FFF_FFFF, 1, "7FFFFFFF", 0});
      directed.push_back('{0, 64'd0, 64'd0, 64'd0, 32'hFFFF_FFFF, 1, "-1", 0});
      directed.push_back('{1, 64'd2, BIN_LO, 64'd0, 32'h8000_0000, 0, "", 0});
      directed.push_back('{0, 64'd0, 64'd0, 64'd0, 32'h7FFF_FFFF, 0, "", 0});
      directed.push_back('{0, 64'd0, 64'd0, 64'd0, 32'd1, 1, "1", 0});
      directed.push_back('{1, 64'hFFFF_FFFF_FFFF_FFF0 | 64'd16, ODD_LO, ODD_HI, 32'd0, 0,
                           "", 0});
      directed.push_back('{0, 64'd0, 64'd0, 64'd0, 32'h89AB_CDEF, 0, "", 0});
      directed.push_back('{0, 64'd0, 64'd0, 64'd0, 32'h7654_3210, 0, "", 0});
      // Invalid alphabets: too small, too large, forbidden characters, repeats.
      directed.push_back('{1, 64'd1, DEC_LO, DEC_HI, 32'd3, 1, "", 1});
      directed.push_back('{1, 64'hFFFF_FFFF_FFFF_FFF1, DEC_LO, HEX_HI, 32'd3, 1, "", 1});
      directed.push_back('{1, 64'hFFFF_FFFF_FFFF_FFFF, DEC_LO, HEX_HI, 32'd3, 1, "", 1});
      directed.push_back('{1, 64'd10, 64'h3736_3534_2B32_3130, DEC_HI, 32'd7, 1, "", 1});
      directed.push_back('{1, 64'd10, DEC_LO, 64'h0000_0000_0000_2D38, 32'd7, 1, "", 1});
      directed.push_back('{1, 64'd16, DEC_LO, 64'h0045_4443_4241_3938, 32'd7, 1, "", 1});
      directed.push_back('{1, 64'd16, DEC_LO, 64'h3045_4443_4241_3938, 32'd7, 1, "", 1});
      directed.push_back('{1, 64'd3, BIN_LO, 64'd0, 32'hFFFF_FFF0, 1, "", 1});

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[r]) begin
         if (directed[r].reconfigure)
            apply_config(directed[r].base_w, {directed[r].hi, directed[r].lo});
         send_request(directed[r].value);
         if (!directed[r].typed)
            predict_text(directed[r].value);
         else if (directed[r].err)
            expected_chars.push_back('{character: CHAR_NUL, last: 1'b1, base_error: 1'b1});
         else
            for (int k = 0; k < directed[r].text.len(); k++)
               expected_chars.push_back('{character: directed[r].text[k],
                                          last: (k == directed[r].text.len() - 1),
                                          base_error: 1'b0});
      end

      random_items = 0;
      while (random_items < RANDOM_REQUESTS) begin
         case ($urandom_range(3))
            0:       base = 2;
            1:       base = MAX_RADIX;
            default: base = $urandom_range(2, MAX_RADIX);
         endcase
         foreach (used[u]) used[u] = 1'b0;
         for (int k = 0; k < MAX_RADIX; k++) begin
            do c = 8'($urandom_range(1, 255));
            while (c == CHAR_PLUS || c == CHAR_MINUS || used[c]);
            used[c] = 1'b1;
            alpha[k*8 +: 8] = c;
         end
         // Roughly one alphabet in eight is broken in one of several ways.
         if ($urandom_range(7) == 0) begin
            i = $urandom_range(0, base - 2);
            j = $urandom_range(i + 1, base - 1);
            case ($urandom_range(4))
               0: begin
                  base = $urandom_range(0, 16);
                  if (base >= 2)
                     base = base + 15;
               end
               1:       alpha[i*8 +: 8] = CHAR_PLUS;
               2:       alpha[i*8 +: 8] = CHAR_MINUS;
               3:       alpha[j*8 +: 8] = CHAR_NUL;
               default: alpha[j*8 +: 8] = alpha[i*8 +: 8];
            endcase
         end
         base_w = {$urandom, $urandom};
         base_w[4:0] = 5'(base);
         apply_config(base_w, alpha);

         burst = $urandom_range(5, 25);
         for (int b = 0; b < burst && random_items < RANDOM_REQUESTS; b++) begin
            no_idle = (random_items >= 120) && (random_items < 180);
            if (random_items % 25 == 24)
               wait_drained();
            case ($urandom_range(5))
               0: v = 32'($urandom_range(0, 300));
               1: v = -32'($urandom_range(1, 300));
               2: begin
                  case ($urandom_range(4))
                     0:       v = 32'd0;
                     1:       v = 32'hFFFF_FFFF;
                     2:       v = 32'd1;
                     3:       v = 32'h7FFF_FFFF;
                     default: v = 32'h8000_0000;
                  endcase
               end
               3: begin
                  v = 32'd1 << $urandom_range(0, 31);
                  if ($urandom_range(1) == 1)
                     v = ~v + 1'b1;
               end
               default: v = $urandom;
            endcase
            send_request(v);
            predict_text(v);
            random_items++;
         end
      end
      no_idle = 1'b0;

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   always @(posedge clock) begin
      char_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_chars.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected response, character %02h last %0b base_error %0b",
                     $time, rsp_character, rsp_last, rsp_base_error);
         end else begin
            want = expected_chars.pop_front();
            if (rsp_character !== want.character) begin
               mismatches++;
               $display("%0t: character expected %02h, actual %02h",
                        $time, want.character, rsp_character);
            end
            if (rsp_last !== want.last) begin
               mismatches++;
               $display("%0t: last expected %0b, actual %0b", $time, want.last, rsp_last);
            end
            if (rsp_base_error !== want.base_error) begin
               mismatches++;
               $display("%0t: base_error expected %0b, actual %0b",
                        $time, want.base_error, rsp_base_error);
            end
         end
      end
      rsp_stall <= !no_idle && ($urandom_range(99) < IDLE_PERCENT);
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("%0t: timeout with %0d characters still expected",
                  $time, expected_chars.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

endmodule
